// File: src/hntp_pkg.sv
// Package for the hash noise texture pixel generator.
// Field widths, register index codes, reset values, hash and divider constants.
// No dependencies.
package hntp_pkg;

   localparam int COORD_W = 12;
   localparam int COLOR_W = 8;
   localparam int GRAIN_W = 9;
   localparam int SEED_W  = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam int NUM_HASH = 4;
   localparam int NUM_CHAN = 3;
   localparam int STAGES   = 6;

   typedef logic [COORD_W-1:0]    coord_type;
   typedef logic [COLOR_W-1:0]    color_type;
   typedef logic [GRAIN_W-1:0]    grain_type;
   typedef logic [SEED_W-1:0]     seed_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOISE_SEED     = 4'd0,
      CSR_GRAIN_STRENGTH = 4'd1,
      CSR_BASE_RED       = 4'd2,
      CSR_BASE_GREEN     = 4'd3,
      CSR_BASE_BLUE      = 4'd4,
      CSR_ACCENT_RED     = 4'd5,
      CSR_ACCENT_GREEN   = 4'd6,
      CSR_ACCENT_BLUE    = 4'd7
   } csr_index_type;

   localparam seed_type  RST_NOISE_SEED   = 32'd37194;
   localparam grain_type RST_GRAIN        = 9'd159;
   localparam color_type RST_BASE_RED     = 8'd59;
   localparam color_type RST_BASE_GREEN   = 8'd56;
   localparam color_type RST_BASE_BLUE    = 8'd51;
   localparam color_type RST_ACCENT_RED   = 8'd179;
   localparam color_type RST_ACCENT_GREEN = 8'd77;
   localparam color_type RST_ACCENT_BLUE  = 8'd31;

   localparam logic [31:0] HASH_MX = 32'd374761393;
   localparam logic [31:0] HASH_MY = 32'd668265263;
   localparam logic [31:0] HASH_MS = 32'd2246822519;
   localparam logic [31:0] HASH_MF = 32'd1274126177;

   // (seed + k) * MS = seed * MS + k * MS, modulo 2^32
   localparam logic [31:0] SEED_OFS_MS [NUM_HASH] = '{
      32'd0,
      32'(64'd17 * 64'(HASH_MS)),
      32'(64'd23 * 64'(HASH_MS)),
      32'(64'd31 * 64'(HASH_MS))
   };

   // Reciprocal multipliers, exact over 12-bit coordinates
   localparam logic [12:0] DIV3_MUL   = 13'd2731;
   localparam int          DIV3_SHIFT = 13;
   localparam logic [12:0] DIV7_MUL   = 13'd4682;
   localparam int          DIV7_SHIFT = 15;
   localparam logic [12:0] DIV13_MUL  = 13'd5042;
   localparam int          DIV13_SHIFT = 16;

   localparam logic [6:0] W_NOISE = 7'd100;
   localparam logic [6:0] W_BROAD = 7'd58;
   localparam logic [6:0] W_MID   = 7'd42;
   localparam logic [5:0] FINE_MASK = 6'd63;

   localparam int NUM_W = 23;
   localparam int T_W   = 17;
   // t = floor(num * 65536 / 6528000) = floor(num * 64 / 6375)
   localparam logic [29:0] TDIV_MUL   = 30'd689889649;
   localparam int          TDIV_SHIFT = 36;

   localparam grain_type GRAIN_FULL = 9'd256;

endpackage

// File: src/hntp_if.sv
// Channel interfaces of the hash noise texture pixel generator.
// Depends on hntp_pkg.
interface hntp_req_if;
   import hntp_pkg::*;
   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface hntp_rsp_if;
   import hntp_pkg::*;
   logic      valid;
   logic      ready;
   color_type red;
   color_type green;
   color_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hntp_csr_if;
   import hntp_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   csr_data_type           data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/hash_noise_texture_pixel.sv
// Hash noise texture pixel generator: six-stage pipeline from req item accepted
// to rsp item valid, one item per cycle sustained while rsp_bus.ready is high.
// Each stage holds while its successor is full and stalled; bubbles collapse.
// Stages: divide, hash sum, hash multiply, mix, blend weight, channel blend.
// Synchronous active-high reset empties the pipeline and restores the CSR
// defaults. Depends on hntp_pkg and hntp_if.
module hash_noise_texture_pixel (
   input logic clock,
   input logic reset,
   hntp_req_if.sink   req_bus,
   hntp_rsp_if.source rsp_bus,
   hntp_csr_if.sink   csr_bus
);
   import hntp_pkg::*;

   // configuration registers
   seed_type  noise_seed_ff;
   grain_type grain_ff;
   color_type base_ff   [NUM_CHAN];
   color_type accent_ff [NUM_CHAN];

   logic [STAGES-1:0] v_ff, v_in;
   logic [STAGES-1:0] rdy;

   // stage 1: cell coordinates, seed product
   coord_type   qx_ff [NUM_HASH], qx_in [NUM_HASH];
   coord_type   qy_ff [NUM_HASH], qy_in [NUM_HASH];
   logic [31:0] sm_ff, sm_in;
   // stage 2: hash sum
   logic [31:0] ha_ff [NUM_HASH], ha_in [NUM_HASH];
   // stage 3: hash product
   logic [31:0] hm_ff [NUM_HASH], hm_in [NUM_HASH];
   // stage 4: blend numerator, fine noise
   logic [NUM_W-1:0] num_ff, num_in;
   logic [5:0]       f4_ff, f4_in;
   // stage 5: blend weight
   logic [T_W-1:0]   t_ff, t_in;
   logic [5:0]       f5_ff;
   // stage 6: output bytes
   color_type rgb_ff [NUM_CHAN], rgb_in [NUM_CHAN];

   // handshake
   always_comb begin
      rdy[STAGES-1] = !v_ff[STAGES-1] || rsp_bus.ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
      v_in[0] = req_bus.valid;
      for (int i = 1; i < STAGES; i++) begin
         v_in[i] = v_ff[i-1];
      end
   end

   assign req_bus.ready = rdy[0];
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = v_ff[STAGES-1];
   assign rsp_bus.red   = rgb_ff[0];
   assign rsp_bus.green = rgb_ff[1];
   assign rsp_bus.blue  = rgb_ff[2];

   // stage 1
   always_comb begin
      logic [27:0] px3, px7, px13, py3, py7, py13;
      px3  = 28'(req_bus.pixel_x) * 28'(DIV3_MUL);
      py3  = 28'(req_bus.pixel_y) * 28'(DIV3_MUL);
      px13 = 28'(req_bus.pixel_x) * 28'(DIV13_MUL);
      py13 = 28'(req_bus.pixel_y) * 28'(DIV13_MUL);
      px7  = 28'(req_bus.pixel_x) * 28'(DIV7_MUL);
      py7  = 28'(req_bus.pixel_y) * 28'(DIV7_MUL);
      qx_in[0] = px3[DIV3_SHIFT +: COORD_W];
      qy_in[0] = py3[DIV3_SHIFT +: COORD_W];
      qx_in[1] = px13[DIV13_SHIFT +: COORD_W];
      qy_in[1] = py13[DIV13_SHIFT +: COORD_W];
      qx_in[2] = px7[DIV7_SHIFT +: COORD_W];
      qy_in[2] = py7[DIV7_SHIFT +: COORD_W];
      qx_in[3] = req_bus.pixel_x;
      qy_in[3] = req_bus.pixel_y;
      sm_in    = noise_seed_ff * HASH_MS;
   end

   // stages 2 and 3
   always_comb begin
      for (int i = 0; i < NUM_HASH; i++) begin
         ha_in[i] = 32'(qx_ff[i]) * HASH_MX + 32'(qy_ff[i]) * HASH_MY
                  + sm_ff + SEED_OFS_MS[i];
         hm_in[i] = (ha_ff[i] ^ (ha_ff[i] >> 13)) * HASH_MF;
      end
   end

   // stage 4
   always_comb begin
      logic [31:0]  h [NUM_HASH];
      grain_type    g;
      grain_type    r;
      for (int i = 0; i < NUM_HASH; i++) begin
         h[i] = hm_ff[i] ^ (hm_ff[i] >> 16);
      end
      g = (grain_ff > GRAIN_FULL) ? GRAIN_FULL : grain_ff;
      r = GRAIN_FULL - g;
      num_in = NUM_W'(h[0][7:0]) * NUM_W'(g) * NUM_W'(W_NOISE)
             + NUM_W'(h[1][7:0]) * NUM_W'(r) * NUM_W'(W_BROAD)
             + NUM_W'(h[2][7:0]) * NUM_W'(r) * NUM_W'(W_MID);
      f4_in  = h[3][5:0] & FINE_MASK;
   end

   // stage 5
   always_comb begin
      logic [52:0] tp;
      tp   = 53'(num_ff) * 53'(TDIV_MUL);
      t_in = tp[TDIV_SHIFT +: T_W];
   end

   // stage 6
   always_comb begin
      logic signed [8:0]  diff;
      logic signed [26:0] term;
      logic signed [26:0] acc;
      logic [8:0]         lvl;
      for (int c = 0; c < NUM_CHAN; c++) begin
         diff = $signed({1'b0, accent_ff[c]}) - $signed({1'b0, base_ff[c]});
         term = 27'(diff) * $signed({10'b0, t_ff});
         lvl  = 9'(base_ff[c]) + 9'(f5_ff);
         acc  = term + $signed({2'b0, lvl, 16'b0});
         if (acc[26]) begin
            rgb_in[c] = '0;
         end else if (|acc[25:24]) begin
            rgb_in[c] = '1;
         end else begin
            rgb_in[c] = acc[23:16];
         end
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         sm_ff <= sm_in;
      end
      if (rdy[1]) begin
         ha_ff <= ha_in;
      end
      if (rdy[2]) begin
         hm_ff <= hm_in;
      end
      if (rdy[3]) begin
         num_ff <= num_in;
         f4_ff  <= f4_in;
      end
      if (rdy[4]) begin
         t_ff  <= t_in;
         f5_ff <= f4_ff;
      end
      if (rdy[5]) begin
         rgb_ff <= rgb_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff <= RST_NOISE_SEED;
         grain_ff      <= RST_GRAIN;
         base_ff[0]    <= RST_BASE_RED;
         base_ff[1]    <= RST_BASE_GREEN;
         base_ff[2]    <= RST_BASE_BLUE;
         accent_ff[0]  <= RST_ACCENT_RED;
         accent_ff[1]  <= RST_ACCENT_GREEN;
         accent_ff[2]  <= RST_ACCENT_BLUE;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_NOISE_SEED:     noise_seed_ff <= csr_bus.data;
            CSR_GRAIN_STRENGTH: grain_ff      <= csr_bus.data[GRAIN_W-1:0];
            CSR_BASE_RED:       base_ff[0]    <= csr_bus.data[COLOR_W-1:0];
            CSR_BASE_GREEN:     base_ff[1]    <= csr_bus.data[COLOR_W-1:0];
            CSR_BASE_BLUE:      base_ff[2]    <= csr_bus.data[COLOR_W-1:0];
            CSR_ACCENT_RED:     accent_ff[0]  <= csr_bus.data[COLOR_W-1:0];
            CSR_ACCENT_GREEN:   accent_ff[1]  <= csr_bus.data[COLOR_W-1:0];
            CSR_ACCENT_BLUE:    accent_ff[2]  <= csr_bus.data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

endmodule
